// ===== src/usbrx_pkg.sv =====
// shared types, constants and pid codes of the usb receive packet decoder
package usbrx_pkg;

    localparam logic [7:0]  PID_RESET_VALUE = 8'hF0;
    localparam logic [15:0] CRC16_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY      = 16'h8005;
    localparam logic [15:0] CRC16_RESIDUAL  = 16'h800D;
    localparam logic [4:0]  CRC5_INIT       = 5'h1F;
    localparam logic [4:0]  CRC5_POLY       = 5'h05;

    // pid type nibbles
    localparam logic [3:0] NIB_OUT   = 4'h1;
    localparam logic [3:0] NIB_IN    = 4'h9;
    localparam logic [3:0] NIB_SOF   = 4'h5;
    localparam logic [3:0] NIB_SETUP = 4'hD;
    localparam logic [3:0] NIB_PING  = 4'h4;
    localparam logic [3:0] NIB_ACK   = 4'h2;
    localparam logic [3:0] NIB_DATA0 = 4'h3;
    localparam logic [3:0] NIB_DATA1 = 4'hB;
    localparam logic [3:0] NIB_DATA2 = 4'h7;
    localparam logic [3:0] NIB_MDATA = 4'hF;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_ACTIVE = 4'b0010,
        PH_TOKEN  = 4'b0100,
        PH_DATA   = 4'b1000
    } phase_t;

    // control from the decoder to the crc16 unit
    typedef struct packed {
        logic clear;
        logic update;
    } crc_ctrl_t;

endpackage

// ===== src/usbrx_crc16.sv =====
// usb crc16 accumulator over data packet bytes, lsb first
module usbrx_crc16
    import usbrx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  crc_ctrl_t   ctrl,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int i = 0; i < 8; i++) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC16_POLY : 16'h0000);
        end
        return c;
    endfunction

    always_comb begin
        crc_next = crc_reg;
        if (ctrl.clear) begin
            crc_next = CRC16_INIT;
        end else if (ctrl.update) begin
            crc_next = crc16_byte(crc_reg, data_in);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC16_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc_out = crc_reg;

endmodule

// ===== src/usb_rx_packet_decoder.sv =====
// usb 1.1 receive packet decoder: pid, token, crc5/crc16 checks and payload delay line
// the result of a transaction appears on the m_ side in the cycle after acceptance
// throughput: one transaction per cycle while m_ready is high; s_ready = !m_valid ||
//   m_ready, so the output register lets a new byte in as the previous result is taken
// reset (aresetn low, synchronous): phase idle, pid 0xF0, crc16 0xFFFF, m_valid and state
//   flags cleared; token bytes, delay line and result fields hold garbage until written
module usb_rx_packet_decoder
    import usbrx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_byte_valid,
    input  logic        s_packet_active,
    input  logic        s_line_error,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pid_byte,
    output logic        m_pid_check_error,
    output logic [10:0] m_token_payload,
    output logic        m_token_valid,
    output logic        m_token_crc_error,
    output logic        m_sequence_error,
    output logic [7:0]  m_data_out,
    output logic        m_data_out_valid,
    output logic        m_data_end,
    output logic        m_data_crc_error,
    output logic        m_busy_res
);

    // ------------------------------------------------------------------
    // decoder state
    // ------------------------------------------------------------------
    phase_t      phase_reg, phase_next;
    logic [7:0]  pid_reg;
    logic [7:0]  tok0_reg;               // token byte one, no reset
    logic [7:0]  tok1_reg;               // token byte two, no reset
    logic [1:0]  tv_pipe_reg, tv_pipe_next;
    logic [7:0]  dly_reg [3];            // payload delay line, no reset
    logic [2:0]  fill_reg, fill_next;    // fill1, fill2, output valid
    logic        act_prev_reg;
    logic [1:0]  busy_reg, busy_next;

    // result register
    logic        m_valid_reg;
    logic [7:0]  m_pid_byte_reg;
    logic        m_pid_check_error_reg;
    logic [10:0] m_token_payload_reg;
    logic        m_token_valid_reg;
    logic        m_token_crc_error_reg;
    logic        m_sequence_error_reg;
    logic [7:0]  m_data_out_reg;
    logic        m_data_out_valid_reg;
    logic        m_data_end_reg;
    logic        m_data_crc_error_reg;
    logic        m_busy_res_reg;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic accept;
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    logic vld, act, err;
    assign vld = s_byte_valid;
    assign act = s_packet_active;
    assign err = s_line_error;

    // ------------------------------------------------------------------
    // pid decode from the latched pid
    // ------------------------------------------------------------------
    logic [3:0] nib;
    logic       is_ack, is_tok, is_dat;
    assign nib    = pid_reg[3:0];
    assign is_ack = (nib == NIB_ACK);
    assign is_tok = (nib == NIB_OUT) || (nib == NIB_IN) || (nib == NIB_SOF) ||
                    (nib == NIB_SETUP) || (nib == NIB_PING);
    assign is_dat = (nib == NIB_DATA0) || (nib == NIB_DATA1) ||
                    (nib == NIB_DATA2) || (nib == NIB_MDATA);

    // ------------------------------------------------------------------
    // phase machine
    // ------------------------------------------------------------------
    logic pid_load, le1, le2, dvd, done, seq, ack;

    always_comb begin
        phase_next = phase_reg;
        pid_load   = 1'b0;
        le1        = 1'b0;
        le2        = 1'b0;
        dvd        = 1'b0;
        done       = 1'b0;
        seq        = 1'b0;
        ack        = 1'b0;
        case (phase_reg)
            PH_IDLE: begin
                // first valid byte of a packet is the pid
                pid_load = act && vld;
                if (vld && act) begin
                    phase_next = PH_ACTIVE;
                end
            end
            PH_ACTIVE: begin
                if (is_ack && !err) begin
                    ack = 1'b1;
                    if (!act) begin
                        phase_next = PH_IDLE;
                    end
                end else if (is_tok && vld && act && !err) begin
                    le1        = 1'b1;
                    phase_next = PH_TOKEN;
                end else if (is_dat && vld && act && !err) begin
                    dvd        = 1'b1;
                    phase_next = PH_DATA;
                end else if (!act || err || (vld && !(is_tok || is_dat))) begin
                    // early end or unknown pid, masked by a line error
                    seq = !err;
                    if (!act) begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_TOKEN: begin
                if (vld && act && !err) begin
                    le2        = 1'b1;
                    phase_next = PH_IDLE;
                end else if (!act || err) begin
                    seq = !err;
                    if (!act) begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_DATA: begin
                if (vld && act && !err) begin
                    dvd = 1'b1;
                end
                // end of packet or a line error closes the data packet
                if (!act || err) begin
                    done = 1'b1;
                    if (!act) begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // token crc5 check on the stored token bytes
    // ------------------------------------------------------------------
    function automatic logic [4:0] crc5_field(input logic [10:0] payload);
        logic [4:0] c;
        logic [4:0] r;
        logic       fb;
        c = CRC5_INIT;
        for (int i = 0; i < 11; i++) begin
            fb = c[4] ^ payload[i];
            c  = {c[3:0], 1'b0} ^ (fb ? CRC5_POLY : 5'h00);
        end
        // inverted and bit reversed, as sent on the wire
        for (int i = 0; i < 5; i++) begin
            r[4 - i] = ~c[i];
        end
        return r;
    endfunction

    logic [10:0] payload;
    logic        tvalid, crc5_bad;
    assign payload  = {tok1_reg[2:0], tok0_reg};
    assign tvalid   = tv_pipe_reg[1];
    assign crc5_bad = tvalid && (crc5_field(payload) != tok1_reg[7:3]);

    // ------------------------------------------------------------------
    // data crc16
    // ------------------------------------------------------------------
    crc_ctrl_t   crc_ctrl;
    logic [15:0] crc_sum;

    // clear on the rising edge of packet_active, update on each payload byte
    assign crc_ctrl = {accept && act && !act_prev_reg, accept && dvd};

    usbrx_crc16 u_crc16 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (crc_ctrl),
        .data_in (s_rx_byte),
        .crc_out (crc_sum)
    );

    // ------------------------------------------------------------------
    // delay line fill flags and busy pipe
    // ------------------------------------------------------------------
    always_comb begin
        fill_next[0] = dvd ? 1'b1 : (done ? 1'b0 : fill_reg[0]);
        fill_next[1] = (fill_reg[0] && dvd) ? 1'b1 : (done ? 1'b0 : fill_reg[1]);
        fill_next[2] = fill_reg[1] && dvd;
    end

    always_comb begin
        busy_next[1] = busy_reg[0];
        if (phase_reg != PH_DATA) begin
            busy_next[0] = 1'b0;
        end else if (vld) begin
            busy_next[0] = 1'b1;
        end else begin
            busy_next[0] = busy_reg[0];
        end
    end

    assign tv_pipe_next = {tv_pipe_reg[0] || ack, le2};

    // ------------------------------------------------------------------
    // control state registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            pid_reg      <= PID_RESET_VALUE;
            tv_pipe_reg  <= 2'b00;
            fill_reg     <= 3'b000;
            act_prev_reg <= 1'b0;
            busy_reg     <= 2'b00;
        end else if (accept) begin
            phase_reg    <= phase_next;
            tv_pipe_reg  <= tv_pipe_next;
            fill_reg     <= fill_next;
            act_prev_reg <= act;
            busy_reg     <= busy_next;
            if (pid_load) begin
                pid_reg <= s_rx_byte;
            end
        end
    end

    // payload stores, written only by data they capture
    always_ff @(posedge aclk) begin
        if (accept && le1) begin
            tok0_reg <= s_rx_byte;
        end
        if (accept && le2) begin
            tok1_reg <= s_rx_byte;
        end
        if (accept && dvd) begin
            dly_reg[2] <= dly_reg[1];
            dly_reg[1] <= dly_reg[0];
            dly_reg[0] <= s_rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_pid_byte_reg        <= pid_reg;
            m_pid_check_error_reg <= (nib != ~pid_reg[7:4]);
            m_token_payload_reg   <= payload;
            m_token_valid_reg     <= tvalid;
            m_token_crc_error_reg <= crc5_bad;
            m_sequence_error_reg  <= seq;
            m_data_out_reg        <= fill_reg[2] ? dly_reg[2] : 8'h00;
            m_data_out_valid_reg  <= fill_reg[2];
            m_data_end_reg        <= done;
            m_data_crc_error_reg  <= done && (crc_sum != CRC16_RESIDUAL);
            m_busy_res_reg        <= busy_reg[1];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_pid_byte        = m_pid_byte_reg;
    assign m_pid_check_error = m_pid_check_error_reg;
    assign m_token_payload   = m_token_payload_reg;
    assign m_token_valid     = m_token_valid_reg;
    assign m_token_crc_error = m_token_crc_error_reg;
    assign m_sequence_error  = m_sequence_error_reg;
    assign m_data_out        = m_data_out_reg;
    assign m_data_out_valid  = m_data_out_valid_reg;
    assign m_data_end        = m_data_end_reg;
    assign m_data_crc_error  = m_data_crc_error_reg;
    assign m_busy_res        = m_busy_res_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fill_order2: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg[2] |-> fill_reg[1])
        else $error("delay line output valid without second fill stage");

    a_fill_order1: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg[1] |-> fill_reg[0])
        else $error("delay line second fill stage without first");

    a_tok_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_crc_error |-> m_token_valid)
        else $error("token crc error reported outside a token transaction");

    a_data_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data_crc_error |-> m_data_end)
        else $error("data crc error reported without end of data packet");

    a_result_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted transaction produced no result");

endmodule

// ===== verif/usbrx_tb_pkg.sv =====
`timescale 1ns / 1ps
// result layout, crc helpers and decode scoreboard for the usb receive decoder testbench
package usbrx_tb_pkg;
    import usbrx_pkg::*;

    typedef struct packed {
        logic [7:0]  pid;
        logic        pid_err;
        logic [10:0] tok;
        logic        tok_vld;
        logic        tok_crc_err;
        logic        seq_err;
        logic [7:0]  dout;
        logic        dout_vld;
        logic        done;
        logic        crc_err;
        logic        busy;
    } decode_result_t;

    typedef struct packed {
        decode_result_t res;
        logic           tok_known;
    } decode_expect_t;

    // crc16 register form, byte fed lsb first
    function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
        logic fb;
        int   i;
        for (i = 0; i < 8; i++) begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0};
            if (fb) crc ^= CRC16_POLY;
        end
        return crc;
    endfunction

    // crc5 field as it sits in bits 7..3 of the second token byte
    function automatic logic [4:0] crc5_stored(logic [10:0] payload);
        logic [4:0] crc;
        logic [4:0] field;
        logic       fb;
        int         i;
        crc = CRC5_INIT;
        for (i = 0; i < 11; i++) begin
            fb  = crc[4] ^ payload[i];
            crc = {crc[3:0], 1'b0};
            if (fb) crc ^= CRC5_POLY;
        end
        for (i = 0; i < 5; i++) field[4-i] = ~crc[i];
        return field;
    endfunction

    class rx_decode_scoreboard;
        int             fail_count;
        decode_expect_t pending_decodes[$];

        phase_t      phase_q;
        logic [7:0]  pid_q;
        logic [7:0]  tok_lo;
        logic [7:0]  tok_hi;
        bit          tok_lo_known;
        bit          tok_hi_known;
        logic [1:0]  tok_pipe;
        logic [15:0] crc16_q;
        logic [7:0]  delay_line [3];
        logic [2:0]  fill_q;
        logic        act_q;
        logic [1:0]  busy_q;

        function new();
            fail_count   = 0;
            phase_q      = PH_IDLE;
            pid_q        = PID_RESET_VALUE;
            tok_lo       = 8'h00;
            tok_hi       = 8'h00;
            tok_lo_known = 1'b0;
            tok_hi_known = 1'b0;
            tok_pipe     = 2'b00;
            crc16_q      = CRC16_INIT;
            delay_line   = '{8'h00, 8'h00, 8'h00};
            fill_q       = 3'b000;
            act_q        = 1'b0;
            busy_q       = 2'b00;
        endfunction

        function int outstanding();
            return pending_decodes.size();
        endfunction

        // one accepted receive cycle: queue its decode, then advance the state
        function void accept_rx_cycle(logic [7:0] rx, logic vld, logic act, logic err);
            logic [3:0]     nib;
            logic [3:0]     inv_hi;
            logic [10:0]    payload;
            bit             is_ack;
            bit             is_tok;
            bit             is_dat;
            bit             pid_load;
            bit             le1;
            bit             le2;
            bit             dvd;
            bit             done;
            bit             seq;
            bit             ack;
            logic           f1;
            logic           f2;
            logic           b0;
            logic           nb0;
            phase_t         nxt;
            decode_expect_t e;

            nib    = pid_q[3:0];
            inv_hi = ~pid_q[7:4];
            is_ack = (nib == NIB_ACK);
            is_tok = (nib == NIB_OUT) || (nib == NIB_IN) || (nib == NIB_SOF) ||
                     (nib == NIB_SETUP) || (nib == NIB_PING);
            is_dat = (nib == NIB_DATA0) || (nib == NIB_DATA1) || (nib == NIB_DATA2) ||
                     (nib == NIB_MDATA);
            nxt      = phase_q;
            pid_load = 0;
            le1      = 0;
            le2      = 0;
            dvd      = 0;
            done     = 0;
            seq      = 0;
            ack      = 0;

            case (phase_q)
                PH_IDLE: begin
                    pid_load = act && vld;
                    if (vld && act) nxt = PH_ACTIVE;
                end
                PH_ACTIVE: begin
                    if (is_ack && !err) begin
                        ack = 1;
                        if (!act) nxt = PH_IDLE;
                    end else if (is_tok && vld && act && !err) begin
                        le1 = 1;
                        nxt = PH_TOKEN;
                    end else if (is_dat && vld && act && !err) begin
                        dvd = 1;
                        nxt = PH_DATA;
                    end else if (!act || err || (vld && !(is_tok || is_dat))) begin
                        seq = !err;
                        if (!act) nxt = PH_IDLE;
                    end
                end
                PH_TOKEN: begin
                    if (vld && act && !err) begin
                        le2 = 1;
                        nxt = PH_IDLE;
                    end else if (!act || err) begin
                        seq = !err;
                        if (!act) nxt = PH_IDLE;
                    end
                end
                default: begin
                    if (vld && act && !err) dvd = 1;
                    if (!act || err) begin
                        done = 1;
                        if (!act) nxt = PH_IDLE;
                    end
                end
            endcase

            payload           = {tok_hi[2:0], tok_lo};
            e.res.pid         = pid_q;
            e.res.pid_err     = (nib != inv_hi);
            e.res.tok         = payload;
            e.res.tok_vld     = tok_pipe[1];
            e.res.tok_crc_err = tok_pipe[1] && (crc5_stored(payload) != tok_hi[7:3]);
            e.res.seq_err     = seq;
            e.res.dout        = fill_q[2] ? delay_line[2] : 8'h00;
            e.res.dout_vld    = fill_q[2];
            e.res.done        = done;
            e.res.crc_err     = done && (crc16_q != CRC16_RESIDUAL);
            e.res.busy        = busy_q[1];
            e.tok_known       = tok_lo_known && tok_hi_known;
            pending_decodes.push_back(e);

            f1        = fill_q[0];
            f2        = fill_q[1];
            fill_q[0] = dvd ? 1'b1 : (done ? 1'b0 : f1);
            fill_q[1] = (f1 && dvd) ? 1'b1 : (done ? 1'b0 : f2);
            fill_q[2] = f2 && dvd;
            if (dvd) begin
                delay_line[2] = delay_line[1];
                delay_line[1] = delay_line[0];
                delay_line[0] = rx;
            end
            if (act && !act_q) crc16_q = CRC16_INIT;
            else if (dvd) crc16_q = crc16_feed(crc16_q, rx);

            b0 = busy_q[0];
            if (phase_q != PH_DATA) nb0 = 1'b0;
            else if (vld) nb0 = 1'b1;
            else nb0 = b0;
            busy_q = {b0, nb0};

            tok_pipe = {tok_pipe[0] || ack, le2};
            if (le1) begin
                tok_lo       = rx;
                tok_lo_known = 1;
            end
            if (le2) begin
                tok_hi       = rx;
                tok_hi_known = 1;
            end
            if (pid_load) pid_q = rx;
            act_q   = act;
            phase_q = nxt;
        endfunction

        function void compare_field(string fname, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
                fail_count++;
            end
        endfunction

        function void check_decode(decode_result_t got);
            decode_expect_t want;
            if (pending_decodes.size() == 0) begin
                $error("decoder result with no pending transaction");
                fail_count++;
                return;
            end
            want = pending_decodes.pop_front();
            compare_field("pid_byte", 16'(want.res.pid), 16'(got.pid));
            compare_field("pid_check_error", 16'(want.res.pid_err), 16'(got.pid_err));
            // token bytes hold garbage until a full token has been captured
            if (want.tok_known)
                compare_field("token_payload", 16'(want.res.tok), 16'(got.tok));
            compare_field("token_valid", 16'(want.res.tok_vld), 16'(got.tok_vld));
            if (want.tok_known || !want.res.tok_vld)
                compare_field("token_crc_error", 16'(want.res.tok_crc_err),
                              16'(got.tok_crc_err));
            compare_field("sequence_error", 16'(want.res.seq_err), 16'(got.seq_err));
            compare_field("data_out", 16'(want.res.dout), 16'(got.dout));
            compare_field("data_out_valid", 16'(want.res.dout_vld), 16'(got.dout_vld));
            compare_field("data_end", 16'(want.res.done), 16'(got.done));
            compare_field("data_crc_error", 16'(want.res.crc_err), 16'(got.crc_err));
            compare_field("busy_res", 16'(want.res.busy), 16'(got.busy));
        endfunction
    endclass

endpackage

// ===== verif/usb_rx_packet_decoder_tb.sv =====
`timescale 1ns / 1ps
// top of the usb receive packet decoder testbench: clock, reset, drivers, monitors and verdict
module usb_rx_packet_decoder_tb;
    import usbrx_pkg::*;
    import usbrx_tb_pkg::*;

    // pids that the decoder does not know
    localparam logic [3:0] NIB_NAK   = 4'hA;
    localparam logic [3:0] NIB_STALL = 4'hE;
    localparam logic [3:0] NIB_NYET  = 4'h6;
    localparam logic [3:0] NIB_PRE   = 4'hC;
    localparam logic [3:0] NIB_SPLIT = 4'h8;
    localparam logic [3:0] NIB_RSVD  = 4'h0;

    localparam int ITEM_TARGET      = 600;     // directed and random items together
    localparam int HOLD_AT          = 300;
    localparam int QUIET_AT         = 540;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES     = 8;
    localparam int CYCLE_LIMIT      = 200000;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        s_byte_valid;
    logic        s_packet_active;
    logic        s_line_error;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_pid_byte;
    logic        m_pid_check_error;
    logic [10:0] m_token_payload;
    logic        m_token_valid;
    logic        m_token_crc_error;
    logic        m_sequence_error;
    logic [7:0]  m_data_out;
    logic        m_data_out_valid;
    logic        m_data_end;
    logic        m_data_crc_error;
    logic        m_busy_res;

    rx_decode_scoreboard sb;
    decode_result_t      observed;
    logic [7:0]          pkt[$];          // bytes of the packet being built
    int                  item_count = 0;
    int                  cycle_count;
    bit                  send_idling = 1'b1;
    bit                  recv_idling = 1'b1;
    bit                  hold_req    = 1'b0;

    usb_rx_packet_decoder u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .s_byte_valid      (s_byte_valid),
        .s_packet_active   (s_packet_active),
        .s_line_error      (s_line_error),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pid_byte        (m_pid_byte),
        .m_pid_check_error (m_pid_check_error),
        .m_token_payload   (m_token_payload),
        .m_token_valid     (m_token_valid),
        .m_token_crc_error (m_token_crc_error),
        .m_sequence_error  (m_sequence_error),
        .m_data_out        (m_data_out),
        .m_data_out_valid  (m_data_out_valid),
        .m_data_end        (m_data_end),
        .m_data_crc_error  (m_data_crc_error),
        .m_busy_res        (m_busy_res)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    assign observed = {m_pid_byte, m_pid_check_error, m_token_payload, m_token_valid,
                       m_token_crc_error, m_sequence_error, m_data_out, m_data_out_valid,
                       m_data_end, m_data_crc_error, m_busy_res};

    // both channels are sampled at the edge, before any of this edge's updates land
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.accept_rx_cycle(s_rx_byte, s_byte_valid, s_packet_active, s_line_error);
            if (m_valid && m_ready)
                sb.check_decode(observed);
        end
    end

    // offer one receive cycle, possibly after a short idle burst, and wait for its transaction
    task automatic push_item(input logic [7:0] b, input logic v, input logic a, input logic e);
        if (send_idling && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_rx_byte       <= b;
        s_byte_valid    <= v;
        s_packet_active <= a;
        s_line_error    <= e;
        do @(posedge aclk); while (!s_ready);
        item_count++;
    endtask

    // play pkt as one packet: valid bytes with occasional stuffing gaps, then end of packet.
    // err_pos marks the byte that carries a line error, -1 for none
    task automatic send_packet(input int err_pos);
        int i;
        // a quiet first cycle of the packet still clears the crc16
        if ($urandom_range(0, 7) == 0) push_item(8'($urandom), 1'b0, 1'b1, 1'b0);
        for (i = 0; i < pkt.size(); i++) begin
            push_item(pkt[i], 1'b1, 1'b1, i == err_pos);
            if ($urandom_range(0, 5) == 0) push_item(8'($urandom), 1'b0, 1'b1, 1'b0);
        end
        repeat ($urandom_range(1, 3)) push_item(8'($urandom), 1'b0, 1'b0, 1'b0);
    endtask

    function automatic logic [3:0] pick_token_nib();
        case ($urandom_range(0, 4))
            0:       return NIB_OUT;
            1:       return NIB_IN;
            2:       return NIB_SOF;
            3:       return NIB_SETUP;
            default: return NIB_PING;
        endcase
    endfunction

    function automatic logic [3:0] pick_data_nib();
        case ($urandom_range(0, 3))
            0:       return NIB_DATA0;
            1:       return NIB_DATA1;
            2:       return NIB_DATA2;
            default: return NIB_MDATA;
        endcase
    endfunction

    // pid, payload low byte, then crc5 over the 11 bits with the payload high bits
    task automatic build_token(input logic [3:0] nib, input logic [10:0] payload,
                               input bit corrupt);
        int idx;
        pkt.delete();
        pkt.push_back({~nib, nib});
        pkt.push_back(payload[7:0]);
        pkt.push_back({crc5_stored(payload), payload[10:8]});
        if (corrupt) begin
            idx = $urandom_range(1, 2);
            pkt[idx] ^= 8'(1 << $urandom_range(0, 7));
        end
    endtask

    // append the two crc16 bytes over everything after the pid: the complement of the
    // register goes out msb first on the wire, and bytes go out lsb first
    task automatic append_crc16();
        logic [15:0] crc;
        logic [7:0]  lo;
        logic [7:0]  hi;
        int          i;
        crc = CRC16_INIT;
        for (i = 1; i < pkt.size(); i++) crc = crc16_feed(crc, pkt[i]);
        crc = ~crc;
        for (i = 0; i < 8; i++) begin
            lo[i] = crc[15-i];
            hi[i] = crc[7-i];
        end
        pkt.push_back(lo);
        pkt.push_back(hi);
    endtask

    task automatic build_data(input logic [3:0] nib, input int len, input bit corrupt);
        int i;
        int idx;
        pkt.delete();
        pkt.push_back({~nib, nib});
        for (i = 0; i < len; i++) pkt.push_back(8'($urandom));
        append_crc16();
        if (corrupt) begin
            idx = $urandom_range(1, pkt.size() - 1);
            pkt[idx] ^= 8'(1 << $urandom_range(0, 7));
        end
    endtask

    // receiver: short random stalls, one long hold-off on request, none at the end
    initial begin
        int hold_count;
        m_ready <= 1'b1;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                // the output register fills and the decoder must stall its input
                hold_req   = 1'b0;
                hold_count = 0;
                m_ready <= 1'b0;
                while (hold_count < LONG_HOLD_CYCLES) begin
                    @(posedge aclk);
                    hold_count++;
                end
            end else if (recv_idling && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("usb_rx_packet_decoder verification failed");
        $finish;
    end

    initial begin
        int         kind;
        int         len;
        int         cut;
        int         err_pos;
        bit         hold_done;
        logic [7:0] pid;
        logic [3:0] nib;

        sb        = new();
        hold_done = 1'b0;
        s_valid         <= 1'b0;
        s_rx_byte       <= 8'h00;
        s_byte_valid    <= 1'b0;
        s_packet_active <= 1'b0;
        s_line_error    <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: a token first so the token bytes are defined from then on
        build_token(NIB_OUT, 11'h000, 1'b0);
        send_packet(-1);
        build_token(NIB_SETUP, 11'h7FF, 1'b0);
        send_packet(-1);
        // payload extremes with a good crc16
        pkt.delete();
        pkt.push_back({~NIB_DATA0, NIB_DATA0});
        pkt.push_back(8'h00);
        pkt.push_back(8'hFF);
        pkt.push_back(8'hA5);
        append_crc16();
        send_packet(-1);
        // ack handshake pulses token_valid
        pkt.delete();
        pkt.push_back({~NIB_ACK, NIB_ACK});
        send_packet(-1);
        // handshake the decoder does not know
        pkt.delete();
        pkt.push_back({~NIB_NAK, NIB_NAK});
        send_packet(-1);
        // zero-length data packet with a broken crc
        build_data(NIB_DATA1, 0, 1'b1);
        send_packet(-1);
        // line error while capturing the token
        build_token(NIB_IN, 11'($urandom), 1'b0);
        send_packet(2);
        // line error in the data phase
        build_data(NIB_DATA2, 2, 1'b0);
        send_packet(3);
        // pid whose check nibble is wrong
        pkt.delete();
        pkt.push_back(8'h11);
        pkt.push_back(8'h5C);
        pkt.push_back(8'hE3);
        send_packet(-1);

        // random: mostly well-formed packets with random content, some broken, some noise
        while (item_count < ITEM_TARGET) begin
            if (!hold_done && item_count >= HOLD_AT) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (item_count >= QUIET_AT) begin
                send_idling = 1'b0;
                recv_idling = 1'b0;
            end
            kind = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            if (kind < 30) begin
                build_data(pick_data_nib(), len, $urandom_range(0, 11) == 0);
                send_packet(-1);
            end else if (kind < 50) begin
                build_token(pick_token_nib(), 11'($urandom), $urandom_range(0, 11) == 0);
                send_packet(-1);
            end else if (kind < 58) begin
                pkt.delete();
                pkt.push_back({~NIB_ACK, NIB_ACK});
                send_packet(-1);
            end else if (kind < 66) begin
                case ($urandom_range(0, 5))
                    0:       nib = NIB_NAK;
                    1:       nib = NIB_STALL;
                    2:       nib = NIB_NYET;
                    3:       nib = NIB_PRE;
                    4:       nib = NIB_SPLIT;
                    default: nib = NIB_RSVD;
                endcase
                pkt.delete();
                pkt.push_back({~nib, nib});
                repeat ($urandom_range(0, 2)) pkt.push_back(8'($urandom));
                send_packet(-1);
            end else if (kind < 74) begin
                // packet cut short before its end
                if ($urandom_range(0, 1)) build_data(pick_data_nib(), len, 1'b0);
                else build_token(pick_token_nib(), 11'($urandom), 1'b0);
                cut = $urandom_range(1, pkt.size() - 1);
                repeat (cut) void'(pkt.pop_back());
                send_packet(-1);
            end else if (kind < 84) begin
                // line error somewhere in a packet
                if ($urandom_range(0, 1)) build_data(pick_data_nib(), len, 1'b0);
                else build_token(pick_token_nib(), 11'($urandom), 1'b0);
                err_pos = $urandom_range(0, pkt.size() - 1);
                send_packet(err_pos);
            end else if (kind < 92) begin
                // pid with a bad check nibble
                pid = 8'($urandom);
                if (pid[7:4] == ~pid[3:0]) pid[4] = ~pid[4];
                pkt.delete();
                pkt.push_back(pid);
                repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
                send_packet(-1);
            end else begin
                // raw noise on every field, then a resync cycle
                repeat ($urandom_range(1, 6))
                    push_item(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
                push_item(8'($urandom), 1'b0, 1'b0, 1'b0);
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.fail_count == 0) begin
            $display("usb_rx_packet_decoder verification clean");
        end else begin
            $display("usb_rx_packet_decoder verification failed");
        end
        $finish;
    end

endmodule
